@@ rtl/core/lsh_pkg.sv @@
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared constants, register codes, the config type and the stage type for the
// 3x3 Laplacian sharpening filter.
// ----------------------------------------------------------------------------
package lsh_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;

   localparam int PIX_W   = 8;
   localparam int RES_W   = 13;
   localparam int CW_W    = 11;                              // image_width register
   localparam int CH_W    = 13;                              // image_height register
   localparam int CSR_D_W = 13;
   localparam int CSR_I_W = 2;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int WE_W    = $clog2(MAX_WIDTH) + 1;           // effective width
   localparam int HE_W    = $clog2(MAX_HEIGHT) + 1;          // effective height
   localparam int ROW_W   = $clog2(MAX_HEIGHT + MAX_WIDTH + 4) + 1;
   localparam int DRN_W   = $clog2(MAX_WIDTH + 2);

   localparam logic [CSR_I_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_I_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_I_W-1:0] CSR_MASK_SELECT  = 2'd2;

   localparam logic [CW_W-1:0] RST_IMAGE_WIDTH  = 11'd512;
   localparam logic [CH_W-1:0] RST_IMAGE_HEIGHT = 13'd512;

   typedef struct packed {
      logic [CW_W-1:0] image_width;
      logic [CH_W-1:0] image_height;
      logic            mask_select;
   } cfg_type;

   // One request after position and edge decisions.
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [PIX_W-1:0] pix;
      logic             emit;
      logic             last;
      logic             edge_sel;   // right-edge result: window before shift
      logic             left_ok;
      logic [2:0]       row_ok;
   } stage_type;

endpackage

@@ rtl/core/lsh_ctrl.sv @@
// ----------------------------------------------------------------------------
// lsh_ctrl
// Position counters, drain handling and the request stage register. Decides
// which result a request produces and which window taps lie inside the image.
// ----------------------------------------------------------------------------
module lsh_ctrl import lsh_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             in_accept,
   input  logic [PIX_W-1:0] pixel,
   input  logic             fill,
   input  logic             a_go,
   output logic             a_valid,
   output stage_type        a_stage,
   output logic [COL_W-1:0] rd_addr
);

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [DRN_W-1:0] drain_ff, drain_in;
   logic             a_valid_ff, a_valid_in;
   stage_type        a_stage_ff, a_stage_in;

   logic [WE_W-1:0]  w_eff;
   logic [HE_W-1:0]  h_eff;
   logic [COL_W-1:0] col1, c;
   logic [ROW_W-1:0] row1, r;
   logic [DRN_W-1:0] drain2;
   logic             done, skip, draining;
   logic [WE_W-1:0]  col3;
   logic [ROW_W:0]   off, k0, k1, k2, hlim;

   always_comb begin
      if (cfg.image_width == '0) begin
         w_eff = WE_W'(1);
      end else if ({21'd0, cfg.image_width} > MAX_WIDTH) begin
         w_eff = WE_W'(MAX_WIDTH);
      end else begin
         w_eff = WE_W'(cfg.image_width);
      end
      if (cfg.image_height == '0) begin
         h_eff = HE_W'(1);
      end else if ({19'd0, cfg.image_height} > MAX_HEIGHT) begin
         h_eff = HE_W'(MAX_HEIGHT);
      end else begin
         h_eff = HE_W'(cfg.image_height);
      end
   end

   always_comb begin
      col1 = col_ff;
      row1 = row_ff;
      if (WE_W'(col_ff) >= w_eff) begin
         col1 = '0;
         row1 = row_ff + ROW_W'(1);
      end
      done = (row1 >= ROW_W'(h_eff)) &&
             ({1'b0, drain_ff} >= (DRN_W+1)'(w_eff) + (DRN_W+1)'(1));
      skip = done && fill;
      c      = col1;
      r      = row1;
      drain2 = drain_ff;
      if (done && !fill) begin
         c      = '0;
         r      = '0;
         drain2 = '0;
      end
      draining = r >= ROW_W'(h_eff);
      drain_in = draining ? drain2 + DRN_W'(1) : drain2;

      a_stage_in.col = c;
      a_stage_in.pix = (draining || fill) ? '0 : pixel;
      a_stage_in.edge_sel = (c == '0);
      if (c == '0) begin
         a_stage_in.emit    = (r >= ROW_W'(2)) && (r < ROW_W'(h_eff) + ROW_W'(2));
         a_stage_in.last    = (r == ROW_W'(h_eff) + ROW_W'(1));
         a_stage_in.left_ok = (w_eff >= WE_W'(2));
      end else begin
         a_stage_in.emit    = (r >= ROW_W'(1)) && (r < ROW_W'(h_eff) + ROW_W'(1));
         a_stage_in.last    = 1'b0;
         a_stage_in.left_ok = (c >= COL_W'(2));
      end

      off  = (c == '0) ? (ROW_W+1)'(3) : (ROW_W+1)'(2);
      hlim = (ROW_W+1)'(h_eff) + off;
      k0   = {1'b0, r};
      k1   = {1'b0, r} + (ROW_W+1)'(1);
      k2   = {1'b0, r} + (ROW_W+1)'(2);
      a_stage_in.row_ok[0] = (k0 >= off) && (k0 < hlim);
      a_stage_in.row_ok[1] = (k1 >= off) && (k1 < hlim);
      a_stage_in.row_ok[2] = (k2 >= off) && (k2 < hlim);

      col3   = WE_W'(c) + WE_W'(1);
      col_in = col3[COL_W-1:0];
      row_in = r;
      if (col3 >= w_eff) begin
         col_in = '0;
         row_in = r + ROW_W'(1);
      end

      if (in_accept) begin
         a_valid_in = !skip;
      end else if (a_go) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         drain_ff   <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         if (in_accept && !skip) begin
            col_ff   <= col_in;
            row_ff   <= row_in;
            drain_ff <= drain_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         a_stage_ff <= a_stage_in;
      end
   end

   assign a_valid = a_valid_ff;
   assign a_stage = a_stage_ff;
   assign rd_addr = c;

endmodule

@@ rtl/core/lsh_line_buf.sv @@
// ----------------------------------------------------------------------------
// lsh_line_buf
// Two row stores with registered reads. A write to the address being read
// in the same cycle is forwarded.
// ----------------------------------------------------------------------------
module lsh_line_buf import lsh_pkg::*; (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [COL_W-1:0] rd_addr,
   input  logic             wr_en,
   input  logic [COL_W-1:0] wr_addr,
   input  logic [PIX_W-1:0] wr_pix,
   output logic [PIX_W-1:0] upper,
   output logic [PIX_W-1:0] middle
);

   logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
   logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

   logic [PIX_W-1:0] rd_up_ff, rd_mid_ff;
   logic [PIX_W-1:0] byp_up_ff, byp_mid_ff;
   logic             byp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_addr]  <= middle;
         middle_mem[wr_addr] <= wr_pix;
      end
      if (rd_en) begin
         rd_up_ff   <= upper_mem[rd_addr];
         rd_mid_ff  <= middle_mem[rd_addr];
         byp_ff     <= wr_en && (wr_addr == rd_addr);
         byp_up_ff  <= middle;
         byp_mid_ff <= wr_pix;
      end
   end

   assign upper  = byp_ff ? byp_up_ff  : rd_up_ff;
   assign middle = byp_ff ? byp_mid_ff : rd_mid_ff;

endmodule

@@ rtl/core/lsh_window.sv @@
// ----------------------------------------------------------------------------
// lsh_window
// 3x3 window registers, masked tap selection, sharpening sum and the
// result register.
// ----------------------------------------------------------------------------
module lsh_window import lsh_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    mask_select,
   input  logic                    a_go,
   input  stage_type               a_stage,
   input  logic [PIX_W-1:0]        upper,
   input  logic [PIX_W-1:0]        middle,
   input  logic                    rsp_take,
   output logic                    rsp_valid,
   output logic signed [RES_W-1:0] rsp_value,
   output logic                    rsp_last
);

   logic [PIX_W-1:0] win_ff [9];
   logic [PIX_W-1:0] win_in [9];
   logic [PIX_W-1:0] new_col [3];
   logic [PIX_W-1:0] tl [3];
   logic [PIX_W-1:0] tc [3];
   logic [PIX_W-1:0] tr [3];

   logic                    rsp_valid_ff;
   logic signed [RES_W-1:0] rsp_value_ff, res_in;
   logic                    rsp_last_ff;
   logic [RES_W-1:0]        f9, f5, s4, dg;

   always_comb begin
      new_col[0] = upper;
      new_col[1] = middle;
      new_col[2] = a_stage.pix;
      for (int i = 0; i < 3; i++) begin
         win_in[i*3+0] = win_ff[i*3+1];
         win_in[i*3+1] = win_ff[i*3+2];
         win_in[i*3+2] = new_col[i];
         tl[i] = (a_stage.row_ok[i] && a_stage.left_ok) ? win_ff[i*3+1] : '0;
         tc[i] = a_stage.row_ok[i] ? win_ff[i*3+2] : '0;
         tr[i] = (a_stage.row_ok[i] && !a_stage.edge_sel) ? new_col[i] : '0;
      end
      f9 = RES_W'({tc[1], 3'b000}) + RES_W'(tc[1]);
      f5 = RES_W'({tc[1], 2'b00}) + RES_W'(tc[1]);
      s4 = RES_W'(tc[0]) + RES_W'(tc[2]) + RES_W'(tl[1]) + RES_W'(tr[1]);
      dg = RES_W'(tl[0]) + RES_W'(tr[0]) + RES_W'(tl[2]) + RES_W'(tr[2]);
      res_in = mask_select ? signed'(f9 - s4 - dg) : signed'(f5 - s4);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < 9; n++) begin
            win_ff[n] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         if (a_go) begin
            for (int n = 0; n < 9; n++) begin
               win_ff[n] <= win_in[n];
            end
         end
         if (a_go && a_stage.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_go && a_stage.emit) begin
         rsp_value_ff <= res_in;
         rsp_last_ff  <= a_stage.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

@@ rtl/core/laplacian_sharpen_3x3.sv @@
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3
// 3x3 Laplacian sharpening of an 8-bit grayscale raster stream, four- or
// eight-neighbour mask, zero padding at the borders, exact signed result.
//
//   channel  dir  handshake             payload
//   req_     in   req_tvalid/tready     tdata pixel_value, tuser fill_item
//   rsp_     out  rsp_tvalid/tready     tdata sharpened_value, tlast frame_last
//   csr_     in   csr_valid/csr_ready   csr_index, csr_data
//
// One request per clock, but a stalled result holds the stage register only
// while the request there produces a result. An accepted request sits in
// the stage register with its row store read; then the window shifts and
// the nine-tap sum lands in the result register. The result for a pixel
// comes out one row plus one pixel of requests later. Synchronous reset
// clears counters, window and valid flags; the row stores are not cleared.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3 import lsh_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // [7:0] pixel_value
   input  logic [0:0]         req_tuser,   // [0] fill_item
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [15:0]        rsp_tdata,   // [12:0] sharpened_value
   output logic               rsp_tlast,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CSR_I_W-1:0] csr_index,
   input  logic [CSR_D_W-1:0] csr_data
);

   cfg_type                 cfg_ff;
   stage_type               a_stage;
   logic                    a_valid, a_go, in_accept, rsp_valid;
   logic [COL_W-1:0]        rd_addr;
   logic [PIX_W-1:0]        upper, middle;
   logic signed [RES_W-1:0] rsp_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= RST_IMAGE_WIDTH;
         cfg_ff.image_height <= RST_IMAGE_HEIGHT;
         cfg_ff.mask_select  <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  cfg_ff.image_width  <= csr_data[CW_W-1:0];
            CSR_IMAGE_HEIGHT: cfg_ff.image_height <= csr_data[CH_W-1:0];
            CSR_MASK_SELECT:  cfg_ff.mask_select  <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign csr_ready  = 1'b1;
   assign a_go       = a_valid && (!rsp_valid || rsp_tready || !a_stage.emit);
   assign req_tready = !a_valid || a_go;
   assign in_accept  = req_tvalid && req_tready;

   lsh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_accept (in_accept),
      .pixel     (req_tdata),
      .fill      (req_tuser[0]),
      .a_go      (a_go),
      .a_valid   (a_valid),
      .a_stage   (a_stage),
      .rd_addr   (rd_addr)
   );

   lsh_line_buf u_line_buf (
      .clock   (clock),
      .rd_en   (in_accept),
      .rd_addr (rd_addr),
      .wr_en   (a_go),
      .wr_addr (a_stage.col),
      .wr_pix  (a_stage.pix),
      .upper   (upper),
      .middle  (middle)
   );

   lsh_window u_window (
      .clock       (clock),
      .reset       (reset),
      .mask_select (cfg_ff.mask_select),
      .a_go        (a_go),
      .a_stage     (a_stage),
      .upper       (upper),
      .middle      (middle),
      .rsp_take    (rsp_tready),
      .rsp_valid   (rsp_valid),
      .rsp_value   (rsp_value),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tvalid = rsp_valid;
   assign rsp_tdata  = {3'b000, rsp_value};

endmodule
